### sv/vcs_pkg.sv
`default_nettype none

package vcs_pkg;

    // Configuration register indexes on the write port.
    localparam int unsigned CFG_ADDR_W = 3;
    typedef logic [CFG_ADDR_W-1:0] cfg_addr_t;

    localparam cfg_addr_t REG_TOTAL_MINUTES     = 3'd0;
    localparam cfg_addr_t REG_FORWARD_TICKS     = 3'd1;
    localparam cfg_addr_t REG_BACKWARD_TICKS    = 3'd2;
    localparam cfg_addr_t REG_PAUSE_TICKS       = 3'd3;
    localparam cfg_addr_t REG_FORWARD_PRESSURE  = 3'd4;
    localparam cfg_addr_t REG_BACKWARD_PRESSURE = 3'd5;

    localparam int unsigned CFG_DATA_W = 16;

    // Reset values of the configuration registers.
    localparam logic [9:0]  TOTAL_MINUTES_RST = 10'd10;
    localparam logic [15:0] PHASE_TICKS_RST   = 16'd100;

    // Smallest access level that may toggle the sequence, minus one.
    localparam logic [3:0] ACCESS_MIN_EXCL = 4'd2;

    // Divide by sixty: shift right by two, then multiply by ceil(2^18 / 15)
    // and drop 18 bits. Exact for every 14-bit dividend.
    localparam logic [14:0] DIV15_RECIP = 15'd17477;
    localparam int unsigned DIV15_SHIFT = 18;

    // Sequencer phases.
    typedef enum logic [3:0] {
        PH_OFF    = 4'd0,
        PH_START  = 4'd1,
        PH_FW_SET = 4'd2,
        PH_FW     = 4'd3,
        PH_FW_END = 4'd4,
        PH_P1_SET = 4'd5,
        PH_P1     = 4'd6,
        PH_P1_END = 4'd7,
        PH_BW_SET = 4'd8,
        PH_BW     = 4'd9,
        PH_BW_END = 4'd10,
        PH_P2_SET = 4'd11,
        PH_P2     = 4'd12,
        PH_P2_END = 4'd13,
        PH_STOP   = 4'd14
    } phase_t;

    // Configuration as seen by the sequencer.
    typedef struct packed {
        logic [9:0]  total_minutes;
        logic [15:0] forward_ticks;
        logic [15:0] backward_ticks;
        logic [15:0] pause_ticks;
        logic [15:0] forward_pressure;
        logic [15:0] backward_pressure;
    } cfg_t;

    // One input beat, last field in the lowest bits.
    typedef struct packed {
        logic       calib_ok;
        logic [3:0] access_level;
        logic       start_toggle;
    } in_item_t;

    // One result beat, last field in the lowest bits.
    typedef struct packed {
        logic        mold_step_clean;
        logic        mold_step_write;
        logic [9:0]  total_elapsed_minutes;
        logic [15:0] phase_elapsed;
        logic        override_active;
        logic [15:0] pressure_set;
        logic        valve_backward;
        logic        valve_forward;
    } result_t;

endpackage

`default_nettype wire

### sv/vcs_cfg_regs.sv
`default_nettype none

module vcs_cfg_regs
    import vcs_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    output cfg_t                       cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Address decode; writes beyond the register list are dropped.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_TOTAL_MINUTES:     cfg_next.total_minutes     = cfg_wdata[9:0];
                REG_FORWARD_TICKS:     cfg_next.forward_ticks     = cfg_wdata;
                REG_BACKWARD_TICKS:    cfg_next.backward_ticks    = cfg_wdata;
                REG_PAUSE_TICKS:       cfg_next.pause_ticks       = cfg_wdata;
                REG_FORWARD_PRESSURE:  cfg_next.forward_pressure  = cfg_wdata;
                REG_BACKWARD_PRESSURE: cfg_next.backward_pressure = cfg_wdata;
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.total_minutes     <= TOTAL_MINUTES_RST;
            cfg_reg.forward_ticks     <= PHASE_TICKS_RST;
            cfg_reg.backward_ticks    <= PHASE_TICKS_RST;
            cfg_reg.pause_ticks       <= PHASE_TICKS_RST;
            cfg_reg.forward_pressure  <= '0;
            cfg_reg.backward_pressure <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

### sv/vcs_seq_core.sv
`default_nettype none

module vcs_seq_core
    import vcs_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     adv,      // the held input beat is consumed this cycle
    input  wire in_item_t item,
    input  wire cfg_t     cfg,
    output result_t       res
);

    phase_t      phase_reg,     phase_next;
    logic [15:0] ph_count_reg,  ph_count_next;
    logic        ph_run_reg,    ph_run_next;
    logic [15:0] ph_limit_reg,  ph_limit_next;
    logic [15:0] tot_count_reg, tot_count_next;
    logic        tot_run_reg,   tot_run_next;
    logic [15:0] tot_limit_reg, tot_limit_next;
    logic [1:0]  valve_reg,     valve_next;
    logic [15:0] press_reg,     press_next;

    logic        permit;
    logic        ph_done;
    logic        tot_done;
    phase_t      phase_mid;
    logic [15:0] shown;
    logic [15:0] tot_limit_calc;
    logic [13:0] tot_quarter;
    logic [28:0] tot_prod;

    // Timer status as it stands at the start of the tick.
    assign ph_done  = ph_run_reg  && (ph_count_reg  >= ph_limit_reg);
    assign tot_done = tot_run_reg && (tot_count_reg >= tot_limit_reg);

    // A permitted toggle starts from off and stops from anywhere else.
    assign permit = (item.access_level > ACCESS_MIN_EXCL) && item.calib_ok
                    && item.start_toggle;

    always_comb
    begin
        phase_mid = phase_reg;
        if (permit)
        begin
            phase_mid = (phase_reg != PH_OFF) ? PH_STOP : PH_START;
        end
    end

    // Minutes times sixty, kept to 16 bits.
    assign tot_limit_calc = ({6'd0, cfg.total_minutes} << 6)
                            - ({6'd0, cfg.total_minutes} << 2);

    // Next phase; expiry of the total timer overrides every transition.
    always_comb
    begin
        unique case (phase_mid)
            PH_OFF:    phase_next = PH_OFF;
            PH_START:  phase_next = PH_FW_SET;
            PH_FW_SET: phase_next = PH_FW;
            PH_FW:     phase_next = ph_done ? PH_FW_END : PH_FW;
            PH_FW_END: phase_next = PH_P1_SET;
            PH_P1_SET: phase_next = PH_P1;
            PH_P1:     phase_next = ph_done ? PH_P1_END : PH_P1;
            PH_P1_END: phase_next = PH_BW_SET;
            PH_BW_SET: phase_next = PH_BW;
            PH_BW:     phase_next = ph_done ? PH_BW_END : PH_BW;
            PH_BW_END: phase_next = PH_P2_SET;
            PH_P2_SET: phase_next = PH_P2;
            PH_P2:     phase_next = ph_done ? PH_P2_END : PH_P2;
            PH_P2_END: phase_next = PH_FW_SET;
            default:   phase_next = PH_OFF;
        endcase
        if (tot_done)
        begin
            phase_next = PH_STOP;
        end
    end

    // Timer controls, valves, pressure and the shown phase time.
    always_comb
    begin
        ph_run_next    = ph_run_reg;
        ph_limit_next  = ph_limit_reg;
        tot_run_next   = tot_run_reg;
        tot_limit_next = tot_limit_reg;
        valve_next     = valve_reg;
        press_next     = press_reg;
        shown          = '0;
        unique case (phase_mid)
            PH_OFF:
            begin
            end
            PH_START:
            begin
                tot_run_next   = 1'b1;
                tot_limit_next = tot_limit_calc;
            end
            PH_FW_SET:
            begin
                ph_run_next   = 1'b1;
                ph_limit_next = cfg.forward_ticks;
            end
            PH_FW:
            begin
                valve_next[0] = 1'b1;
                press_next    = cfg.forward_pressure;
                shown         = ph_done ? 16'd0 : ph_count_reg;
                if (ph_done)
                begin
                    ph_run_next = 1'b0;
                end
            end
            PH_FW_END:
            begin
                valve_next[0] = 1'b0;
                press_next    = '0;
            end
            PH_P1_SET, PH_P2_SET:
            begin
                ph_run_next   = 1'b1;
                ph_limit_next = cfg.pause_ticks;
            end
            PH_P1, PH_P2:
            begin
                shown = ph_done ? 16'd0 : ph_count_reg;
                if (ph_done)
                begin
                    ph_run_next = 1'b0;
                end
            end
            PH_P1_END, PH_P2_END:
            begin
            end
            PH_BW_SET:
            begin
                ph_run_next   = 1'b1;
                ph_limit_next = cfg.backward_ticks;
            end
            PH_BW:
            begin
                valve_next[1] = 1'b1;
                press_next    = cfg.backward_pressure;
                shown         = ph_done ? 16'd0 : ph_count_reg;
                if (ph_done)
                begin
                    ph_run_next = 1'b0;
                end
            end
            PH_BW_END:
            begin
                valve_next[1] = 1'b0;
                press_next    = '0;
            end
            default:
            begin
                // Stop, and the one unused code, which behaves the same.
                ph_run_next  = 1'b0;
                tot_run_next = 1'b0;
                press_next   = '0;
                valve_next   = '0;
            end
        endcase
    end

    // On-delay counters: count up to the limit while running, clear otherwise.
    always_comb
    begin
        ph_count_next = '0;
        if (ph_run_next)
        begin
            ph_count_next = (ph_count_reg < ph_limit_next) ? ph_count_reg + 16'd1
                                                           : ph_count_reg;
        end
        tot_count_next = '0;
        if (tot_run_next)
        begin
            tot_count_next = (tot_count_reg < tot_limit_next) ? tot_count_reg + 16'd1
                                                              : tot_count_reg;
        end
    end

    // Elapsed minutes from the count at the start of the tick.
    assign tot_quarter = tot_count_reg[15:2];
    assign tot_prod    = {15'd0, tot_quarter} * {14'd0, DIV15_RECIP};

    always_comb
    begin
        res.valve_forward         = valve_next[0];
        res.valve_backward        = valve_next[1];
        res.pressure_set          = press_next;
        res.override_active       = (phase_next != PH_OFF);
        res.phase_elapsed         = shown;
        res.total_elapsed_minutes = tot_prod[DIV15_SHIFT +: 10];
        res.mold_step_write       = permit;
        res.mold_step_clean       = permit && (phase_reg == PH_OFF);
    end

    // State advances once per consumed beat.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_STOP;
            ph_count_reg  <= '0;
            ph_run_reg    <= 1'b0;
            ph_limit_reg  <= '0;
            tot_count_reg <= '0;
            tot_run_reg   <= 1'b0;
            tot_limit_reg <= '0;
            valve_reg     <= '0;
            press_reg     <= '0;
        end
        else if (adv)
        begin
            phase_reg     <= phase_next;
            ph_count_reg  <= ph_count_next;
            ph_run_reg    <= ph_run_next;
            ph_limit_reg  <= ph_limit_next;
            tot_count_reg <= tot_count_next;
            tot_run_reg   <= tot_run_next;
            tot_limit_reg <= tot_limit_next;
            valve_reg     <= valve_next;
            press_reg     <= press_next;
        end
    end

endmodule

`default_nettype wire

### sv/valve_clean_sequencer.sv
`default_nettype none

// Channel   Direction  Ports                           Beat
// s         in         s_tvalid s_tready s_tdata[7:0]  one control tick
// m         out        m_tvalid m_tready m_tdata[47:0] one result per tick
// cfg       in         cfg_we cfg_addr[2:0] cfg_wdata  one register write
//
// Every input beat gives exactly one result beat; it passes through the input
// register and then the result register before it is shown on m.
// A new beat is taken every cycle while the result side keeps up; the
// sequencer state updates in one pass as the held beat moves to the result.
// When m_tready is low, both registers fill and s_tready drops; nothing is lost.
// Reset is asynchronous; the sequencer comes up in the stop phase.

module valve_clean_sequencer
    import vcs_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // [0] start_toggle, [4:1] access_level, [5] calib_ok, [7:6] zero
    input  wire logic [7:0]            s_tdata,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // [0] valve_forward, [1] valve_backward, [17:2] pressure_set,
    // [18] override_active, [34:19] phase_elapsed,
    // [44:35] total_elapsed_minutes, [45] mold_step_write,
    // [46] mold_step_clean, [47] zero
    output logic [47:0]                m_tdata,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

    cfg_t     cfg;
    in_item_t in_item_reg;
    logic     in_valid_reg;
    result_t  out_reg;
    logic     out_valid_reg;
    result_t  res;
    logic     adv;

    vcs_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    vcs_seq_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .adv   (adv),
        .item  (in_item_reg),
        .cfg   (cfg),
        .res   (res)
    );

    // The held beat moves on when the result register is free or draining.
    assign adv      = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || adv;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_item_reg <= s_tdata[5:0];
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || m_tready)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_reg};

endmodule

`default_nettype wire
